FILE: hdl/valid_marked_sample_store_min_max_unit_defines.svh
// ----------------------------------------------------------------------------
// valid-marked sample store - assertion macros
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef VALID_MARKED_SAMPLE_STORE_MIN_MAX_UNIT_DEFINES_SVH
`define VALID_MARKED_SAMPLE_STORE_MIN_MAX_UNIT_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every edge out of reset
`define VMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
// antecedent in one cycle implies consequent in the next
`define VMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);
`else
`define VMS_ASSERT(label, clk, rst_n, prop, msg)
`define VMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/vmsmm_pkg.sv
// ----------------------------------------------------------------------------
// vmsmm_pkg
// shared constants, types and helpers of the valid-marked sample store
// ----------------------------------------------------------------------------
`default_nettype none

package vmsmm_pkg;

    // store geometry
    localparam int SLOT_COUNT = 512;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    // valid marks are kept in rows of 32 bits
    localparam int MARK_SH    = 5;
    localparam int MARK_W     = 1 << MARK_SH;
    localparam int MARK_ROWS  = (SLOT_COUNT + MARK_W - 1) / MARK_W;
    localparam int ROW_W      = (MARK_ROWS > 1) ? $clog2(MARK_ROWS) : 1;

    // field widths
    localparam int FUNC_W     = 2;
    localparam int SLOT_IDX_W = 16;
    localparam int PRICE_W    = 31;
    localparam int SUM_W      = PRICE_W + 1;
    localparam int THR_W      = 16;
    localparam int OUT_IDX_W  = 10;

    localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
    localparam logic [THR_W-1:0]   FLAT_THR_RESET = 16'd100;

    // widening: lo = avg - q, hi = avg + q + (rem == 999), q = (5*avg + 499) / 1000
    localparam int DIV_CONST  = 1000;
    localparam int ROUND_BIAS = 499;
    localparam int DIV_W      = 34;
    localparam int REM_W      = $clog2(DIV_CONST);

    // divide by 1000 as a shift by 3 and a multiply by ceil(2^38 / 125)
    localparam int PRE_SH     = 3;
    localparam int RECIP_SH   = 38;
    localparam int RECIP_W    = 32;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 32'd2199023256;
    localparam int PROD_W     = DIV_W - PRE_SH + RECIP_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIVCNT_W   = $clog2(DIV_STEPS + 1);

    // stream and register port widths
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = FUNC_W;
    localparam int M_TDATA_W  = 96;
    localparam int APB_DW     = 32;
    localparam int PADDR_W    = 3;
    localparam logic REG_FLAT_THR = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_RECOMP = 2'd2
    } t_func;

    typedef struct packed {
        logic load_item;
        logic modify;
        logic scan_start;
        logic scan_step;
        logic ld_avg;
        logic div_load;
        logic div_step;
        logic commit_plain;
        logic commit_wide;
        logic ld_result;
    } t_ctrl_cmd;

    typedef struct packed {
        logic recompute_go;
        logic scan_last;
        logic flat;
        logic div_done;
        logic out_busy;
    } t_dp_status;

    function automatic logic [ROW_W-1:0] row_of(input logic [SLOT_IDX_W-1:0] s);
        return ROW_W'(s >> MARK_SH);
    endfunction

    function automatic logic [MARK_SH-1:0] bit_of(input logic [SLOT_IDX_W-1:0] s);
        return s[MARK_SH-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/vmsmm_ram.sv
// ----------------------------------------------------------------------------
// vmsmm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module vmsmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/vmsmm_ctrl.sv
// ----------------------------------------------------------------------------
// vmsmm_ctrl
// sequencer for one item at a time: mark lookup, update, scan, widen, report
// ----------------------------------------------------------------------------
`default_nettype none

module vmsmm_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  vmsmm_pkg::t_dp_status  i_status,
    output vmsmm_pkg::t_ctrl_cmd   o_cmd
);

    import vmsmm_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_READ   = 10'b0000000010,
        ST_MODIFY = 10'b0000000100,
        ST_SCAN   = 10'b0000001000,
        ST_DRAIN  = 10'b0000010000,
        ST_AVG    = 10'b0000100000,
        ST_DECIDE = 10'b0001000000,
        ST_DIV    = 10'b0010000000,
        ST_COMMIT = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_MODIFY;
            end
            ST_MODIFY: begin
                o_cmd.modify = 1'b1;
                if (i_status.recompute_go) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_AVG;
            end
            ST_AVG: begin
                o_cmd.ld_avg = 1'b1;
                n_state      = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_status.flat) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = ST_DIV;
                end else begin
                    o_cmd.commit_plain = 1'b1;
                    n_state            = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_COMMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit_wide = 1'b1;
                n_state           = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.ld_result = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/vmsmm_dp.sv
// ----------------------------------------------------------------------------
// vmsmm_dp
// store, mark rows, counters, min/max scan, widening divider, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "valid_marked_sample_store_min_max_unit_defines.svh"

module vmsmm_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  vmsmm_pkg::t_ctrl_cmd                 i_cmd,
    output vmsmm_pkg::t_dp_status                o_status,
    input  logic [vmsmm_pkg::FUNC_W-1:0]         i_func,
    input  logic [vmsmm_pkg::SLOT_IDX_W-1:0]     i_slot_index,
    input  logic [vmsmm_pkg::PRICE_W-1:0]        i_price_value,
    input  logic [vmsmm_pkg::THR_W-1:0]          i_flat_range_threshold,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [vmsmm_pkg::M_TDATA_W-1:0]      o_m_tdata
);

    import vmsmm_pkg::*;

    // item registers
    t_func                  r_func;
    logic [SLOT_IDX_W-1:0]  r_slot;
    logic [PRICE_W-1:0]     r_price;
    logic                   r_in_range;
    logic                   r_was;

    // store status
    logic [MARK_ROWS-1:0]   r_row_valid;
    logic [CNT_W-1:0]       r_count;
    logic                   r_any;
    logic [SLOT_W-1:0]      r_first;
    logic [SLOT_W-1:0]      r_last;
    logic [PRICE_W-1:0]     r_min;
    logic [PRICE_W-1:0]     r_max;

    // scan
    logic [SLOT_W-1:0]      r_scan;
    logic                   r_scan_pend;
    logic [MARK_SH-1:0]     r_scan_bit;
    logic                   r_mark_rowv;
    logic [PRICE_W-1:0]     r_lo;
    logic [PRICE_W-1:0]     r_hi;

    // widening
    logic [PRICE_W-1:0]     r_avg;
    logic                   r_flat;
    logic [DIV_W-1:0]       r_dq;
    logic [PROD_W-1:0]      r_prod;
    logic [PRICE_W-1:0]     r_quot;
    logic [REM_W-1:0]       r_rem;
    logic [DIVCNT_W-1:0]    r_div_cnt;

    // result
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;

    // ram ports
    logic [ROW_W-1:0]       mark_raddr;
    logic [ROW_W-1:0]       item_row;
    logic [MARK_W-1:0]      mark_q;
    logic [MARK_W-1:0]      mark_row;
    logic [MARK_W-1:0]      mark_wdata;
    logic [PRICE_W-1:0]     price_q;
    logic                   store_we;
    logic                   slot_mark;
    logic                   scan_mark;

    logic [SLOT_W-1:0]      slot_s;
    logic [SUM_W-1:0]       pair_sum;
    logic [PRICE_W-1:0]     spread;
    logic                   flat_now;
    logic [DIV_W-1:0]       div_init;
    logic [PROD_W-1:0]      div_prod;
    logic [PRICE_W-1:0]     quot_next;
    logic [REM_W-1:0]       rem_next;
    logic [PRICE_W-1:0]     quot;
    logic                   round_up;
    logic [PRICE_W-1:0]     wide_lo;
    logic [SUM_W-1:0]       wide_sum;
    logic [PRICE_W-1:0]     wide_hi;

    logic [SLOT_IDX_W-1:0]  cnt16;
    logic [SLOT_IDX_W-1:0]  first16;
    logic [SLOT_IDX_W-1:0]  last16;
    logic [OUT_IDX_W-1:0]   first_out;
    logic [OUT_IDX_W-1:0]   last_out;

    assign item_row   = row_of(r_slot);
    assign slot_s     = r_slot[SLOT_W-1:0];
    assign mark_raddr = i_cmd.scan_step ? row_of(SLOT_IDX_W'(r_scan)) : item_row;
    assign mark_row   = r_mark_rowv ? mark_q : '0;
    assign slot_mark  = r_in_range && mark_row[bit_of(r_slot)];
    assign scan_mark  = r_scan_pend && r_mark_rowv && mark_q[r_scan_bit];
    assign mark_wdata = mark_row | (MARK_W'(1) << bit_of(r_slot));
    assign store_we   = i_cmd.modify && (r_func == FUNC_WRITE) && r_in_range;

    vmsmm_ram #(
        .WIDTH (MARK_W),
        .DEPTH (MARK_ROWS)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (item_row),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_q)
    );

    vmsmm_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (SLOT_COUNT)
    ) u_price_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (slot_s),
        .i_wdata (r_price),
        .i_raddr (r_scan),
        .o_rdata (price_q)
    );

    // average and spread of the scanned extremes
    assign pair_sum = {1'b0, r_hi} + {1'b0, r_lo};
    assign spread   = r_hi - r_lo;
    assign flat_now = (r_hi >= r_lo) && (spread < PRICE_W'(i_flat_range_threshold));

    // 5*avg + 499 by shift and add
    assign div_init = DIV_W'({r_avg, 2'b00}) + DIV_W'(r_avg) + DIV_W'(ROUND_BIAS);

    // q = floor(x / 1000) = ((x >> 3) * ceil(2^38 / 125)) >> 38, exact for x below 2^34
    assign div_prod  = PROD_W'(r_dq[DIV_W-1:PRE_SH]) * PROD_W'(DIV_RECIP);
    assign quot_next = PRICE_W'(r_prod[PROD_W-1:RECIP_SH]);
    // remainder is under 1000, so ten bits of x - 1000*q do, and 1000*q wraps to -24*q
    assign rem_next  = r_dq[REM_W-1:0] + REM_W'(quot_next << 4) + REM_W'(quot_next << 3);

    assign quot     = r_quot;
    assign round_up = (r_rem == REM_W'(DIV_CONST - 1));
    assign wide_lo  = r_avg - quot;
    assign wide_sum = {1'b0, r_avg} + {1'b0, quot} + SUM_W'(round_up);
    assign wide_hi  = wide_sum[PRICE_W] ? PRICE_MAX : wide_sum[PRICE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func     <= t_func'(i_func);
            r_slot     <= i_slot_index;
            r_price    <= i_price_value;
            r_in_range <= (i_slot_index < SLOT_IDX_W'(SLOT_COUNT));
        end
        if (i_cmd.modify) begin
            r_was <= slot_mark;
        end
        // row flag is registered from the read address, like the ram read data
        r_mark_rowv <= r_row_valid[mark_raddr];
        r_scan_bit  <= bit_of(SLOT_IDX_W'(r_scan));
    end

    // store status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_count     <= '0;
            r_any       <= 1'b0;
            r_min       <= PRICE_MAX;
            r_max       <= '0;
        end else begin
            if (i_cmd.modify) begin
                case (r_func)
                    FUNC_CLEAR: begin
                        r_row_valid <= '0;
                        r_count     <= '0;
                        r_any       <= 1'b0;
                        r_min       <= PRICE_MAX;
                        r_max       <= '0;
                    end
                    FUNC_WRITE: begin
                        if (r_in_range) begin
                            r_row_valid[item_row] <= 1'b1;
                            if (!slot_mark) begin
                                r_count <= r_count + CNT_W'(1);
                                r_any   <= 1'b1;
                            end
                        end
                    end
                    FUNC_RECOMP: begin
                        if (!r_any) begin
                            r_min <= PRICE_MAX;
                            r_max <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit_plain) begin
                r_min <= r_lo;
                r_max <= r_hi;
            end
            if (i_cmd.commit_wide) begin
                r_min <= wide_lo;
                r_max <= wide_hi;
            end
        end
    end

    // first and last valid slot only grow outwards between clears
    always_ff @(posedge i_clk) begin
        if (store_we && !slot_mark) begin
            if (!r_any || (slot_s < r_first)) begin
                r_first <= slot_s;
            end
            if (!r_any || (slot_s > r_last)) begin
                r_last <= slot_s;
            end
        end
    end

    // scan over all slots, compare follows the read in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pend <= 1'b0;
        end else begin
            r_scan_pend <= i_cmd.scan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan <= '0;
            r_lo   <= PRICE_MAX;
            r_hi   <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_scan <= r_scan + SLOT_W'(1);
            end
            if (scan_mark) begin
                if (price_q < r_lo) begin
                    r_lo <= price_q;
                end
                if (price_q > r_hi) begin
                    r_hi <= price_q;
                end
            end
        end
    end

    // widening unit: multiply step, then quotient and remainder step
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_avg) begin
            r_avg  <= pair_sum[PRICE_W:1];
            r_flat <= flat_now;
        end
        if (i_cmd.div_load) begin
            r_dq      <= div_init;
            r_div_cnt <= DIVCNT_W'(DIV_STEPS);
        end else if (i_cmd.div_step) begin
            if (r_div_cnt == DIVCNT_W'(DIV_STEPS)) begin
                r_prod <= div_prod;
            end else begin
                r_quot <= quot_next;
                r_rem  <= rem_next;
            end
            r_div_cnt <= r_div_cnt - DIVCNT_W'(1);
        end
    end

    // result register
    assign cnt16     = SLOT_IDX_W'(r_count);
    assign first16   = SLOT_IDX_W'(r_first);
    assign last16    = SLOT_IDX_W'(r_last);
    assign first_out = r_any ? first16[OUT_IDX_W-1:0] : '1;
    assign last_out  = r_any ? last16[OUT_IDX_W-1:0] : '1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_result) begin
            r_out_data <= {3'b000, r_was, r_max, r_min, last_out, first_out,
                           cnt16[OUT_IDX_W-1:0]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign o_status.recompute_go = (r_func == FUNC_RECOMP) && r_any;
    assign o_status.scan_last    = (r_scan == SLOT_W'(SLOT_COUNT - 1));
    assign o_status.flat         = r_flat;
    assign o_status.div_done     = (r_div_cnt == '0);
    assign o_status.out_busy     = r_out_valid && !i_m_tready;

    `VMS_ASSERT(a_any_tracks_count, i_clk, i_rst_n, r_any == (r_count != '0), "count and occupancy flag disagree")
    `VMS_ASSERT(a_first_not_after_last, i_clk, i_rst_n, !r_any || (r_first <= r_last), "first valid slot lies above last")
    `VMS_ASSERT_NEXT(a_commit_ordered, i_clk, i_rst_n, i_cmd.commit_plain || i_cmd.commit_wide, r_min <= r_max, "committed min above max")

endmodule

`default_nettype wire

FILE: hdl/valid_marked_sample_store_min_max_unit.sv
// sequencing: clear, write and an empty recompute pass from accept through read, modify
//   and finish states to the result; a new item is taken only once the last result is
//   loaded; a recompute over a non-empty store scans every slot through the price ram
//   read port, and widening the range adds a two-step reciprocal divide by 1000
// reset: synchronous active low, clears all valid marks at once (row flags), count,
//   min to 2147483647, max to 0, threshold to 100; price ram is not cleared
// ----------------------------------------------------------------------------
// valid_marked_sample_store_min_max_unit
// slot store of scaled prices with valid marks, count and min/max recompute
// ----------------------------------------------------------------------------
`default_nettype none

module valid_marked_sample_store_min_max_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot_index [15:0], price_value [46:16], zero pad [47]
    input  logic [vmsmm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func [1:0]
    input  logic [vmsmm_pkg::S_TUSER_W-1:0] s_axis_tuser,

    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // valid_count [9:0], first_valid_slot [19:10], last_valid_slot [29:20],
    // range_min [60:30], range_max [91:61], slot_was_valid [92], zero pad [95:93]
    output logic [vmsmm_pkg::M_TDATA_W-1:0] m_axis_tdata,

    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vmsmm_pkg::PADDR_W-1:0]   paddr,
    input  logic [vmsmm_pkg::APB_DW-1:0]    pwdata,
    output logic [vmsmm_pkg::APB_DW-1:0]    prdata,
    output logic                            pready
);

    import vmsmm_pkg::*;

    t_ctrl_cmd         cmd;
    t_dp_status        status;
    logic [THR_W-1:0]  r_flat_thr;
    logic              reg_write;

    // register file: one threshold word at byte address 0, zero-wait access
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat_thr <= FLAT_THR_RESET;
        end else if (reg_write && (paddr[2] == REG_FLAT_THR)) begin
            r_flat_thr <= pwdata[THR_W-1:0];
        end
    end

    // addresses with paddr[2] set read as zero; the others read the threshold
    assign prdata = (paddr[2] == REG_FLAT_THR) ? APB_DW'(r_flat_thr) : '0;

    // sequencer: one item in flight, result register lets the next item in
    vmsmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: mark rows and price ram, counters, scan, widening divider
    vmsmm_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_status               (status),
        .i_func                 (s_axis_tuser[FUNC_W-1:0]),
        .i_slot_index           (s_axis_tdata[SLOT_IDX_W-1:0]),
        .i_price_value          (s_axis_tdata[SLOT_IDX_W+PRICE_W-1:SLOT_IDX_W]),
        .i_flat_range_threshold (r_flat_thr),
        .i_m_tready             (m_axis_tready),
        .o_m_tvalid             (m_axis_tvalid),
        .o_m_tdata              (m_axis_tdata)
    );

endmodule

`default_nettype wire
